/* sv/sha512_pkg.sv */
// Package: SHA-512 engine types, constants and round functions.
`timescale 1ns / 1ps
package sha512_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  valid_bytes;
        logic        end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        digest_done;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    localparam logic [63:0] PAD_WORD = 64'h8000000000000000;
    localparam logic [3:0]  LEN_SLOT = 4'd14;

    function automatic logic [63:0] init_hash(input logic [2:0] i);
        logic [63:0] v;
        case (i)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] r);
        logic [63:0] v;
        case (r)
            7'd0: v = 64'h428a2f98d728ae22;  7'd1: v = 64'h7137449123ef65cd;
            7'd2: v = 64'hb5c0fbcfec4d3b2f;  7'd3: v = 64'he9b5dba58189dbbc;
            7'd4: v = 64'h3956c25bf348b538;  7'd5: v = 64'h59f111f1b605d019;
            7'd6: v = 64'h923f82a4af194f9b;  7'd7: v = 64'hab1c5ed5da6d8118;
            7'd8: v = 64'hd807aa98a3030242;  7'd9: v = 64'h12835b0145706fbe;
            7'd10: v = 64'h243185be4ee4b28c; 7'd11: v = 64'h550c7dc3d5ffb4e2;
            7'd12: v = 64'h72be5d74f27b896f; 7'd13: v = 64'h80deb1fe3b1696b1;
            7'd14: v = 64'h9bdc06a725c71235; 7'd15: v = 64'hc19bf174cf692694;
            7'd16: v = 64'he49b69c19ef14ad2; 7'd17: v = 64'hefbe4786384f25e3;
            7'd18: v = 64'h0fc19dc68b8cd5b5; 7'd19: v = 64'h240ca1cc77ac9c65;
            7'd20: v = 64'h2de92c6f592b0275; 7'd21: v = 64'h4a7484aa6ea6e483;
            7'd22: v = 64'h5cb0a9dcbd41fbd4; 7'd23: v = 64'h76f988da831153b5;
            7'd24: v = 64'h983e5152ee66dfab; 7'd25: v = 64'ha831c66d2db43210;
            7'd26: v = 64'hb00327c898fb213f; 7'd27: v = 64'hbf597fc7beef0ee4;
            7'd28: v = 64'hc6e00bf33da88fc2; 7'd29: v = 64'hd5a79147930aa725;
            7'd30: v = 64'h06ca6351e003826f; 7'd31: v = 64'h142929670a0e6e70;
            7'd32: v = 64'h27b70a8546d22ffc; 7'd33: v = 64'h2e1b21385c26c926;
            7'd34: v = 64'h4d2c6dfc5ac42aed; 7'd35: v = 64'h53380d139d95b3df;
            7'd36: v = 64'h650a73548baf63de; 7'd37: v = 64'h766a0abb3c77b2a8;
            7'd38: v = 64'h81c2c92e47edaee6; 7'd39: v = 64'h92722c851482353b;
            7'd40: v = 64'ha2bfe8a14cf10364; 7'd41: v = 64'ha81a664bbc423001;
            7'd42: v = 64'hc24b8b70d0f89791; 7'd43: v = 64'hc76c51a30654be30;
            7'd44: v = 64'hd192e819d6ef5218; 7'd45: v = 64'hd69906245565a910;
            7'd46: v = 64'hf40e35855771202a; 7'd47: v = 64'h106aa07032bbd1b8;
            7'd48: v = 64'h19a4c116b8d2d0c8; 7'd49: v = 64'h1e376c085141ab53;
            7'd50: v = 64'h2748774cdf8eeb99; 7'd51: v = 64'h34b0bcb5e19b48a8;
            7'd52: v = 64'h391c0cb3c5c95a63; 7'd53: v = 64'h4ed8aa4ae3418acb;
            7'd54: v = 64'h5b9cca4f7763e373; 7'd55: v = 64'h682e6ff3d6b2b8a3;
            7'd56: v = 64'h748f82ee5defb2fc; 7'd57: v = 64'h78a5636f43172f60;
            7'd58: v = 64'h84c87814a1f0ab72; 7'd59: v = 64'h8cc702081a6439ec;
            7'd60: v = 64'h90befffa23631e28; 7'd61: v = 64'ha4506cebde82bde9;
            7'd62: v = 64'hbef9a3f7b2c67915; 7'd63: v = 64'hc67178f2e372532b;
            7'd64: v = 64'hca273eceea26619c; 7'd65: v = 64'hd186b8c721c0c207;
            7'd66: v = 64'heada7dd6cde0eb1e; 7'd67: v = 64'hf57d4f7fee6ed178;
            7'd68: v = 64'h06f067aa72176fba; 7'd69: v = 64'h0a637dc5a2c898a6;
            7'd70: v = 64'h113f9804bef90dae; 7'd71: v = 64'h1b710b35131c471b;
            7'd72: v = 64'h28db77f523047d84; 7'd73: v = 64'h32caab7b40c72493;
            7'd74: v = 64'h3c9ebe0a15c9bebc; 7'd75: v = 64'h431d67c49c100d4c;
            7'd76: v = 64'h4cc5d4becb3e42b6; 7'd77: v = 64'h597f299cfc657e2a;
            7'd78: v = 64'h5fcb6fab3ad6faec; default: v = 64'h6c44198c4a475817;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] ror(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

/* sv/sha512_hash_engine.sv */
// SHA-512 engine: word gathering, padding and iterative 80-round compression.
// A non-last word leaves s_ready high; the word that fills a block holds s_ready low
// through 80 rounds in the single round unit and then a fold state.
// A last word adds the padding words, one or two compressions and eight digest
// transactions.
// Reset (aresetn low, synchronous) restores the initial hash and clears the counters.
`timescale 1ns / 1ps
module sha512_hash_engine (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  sha512_pkg::in_item_t     s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output sha512_pkg::out_item_t    m_data
);

    sha512_pkg::state_t state_reg, state_next;

    logic [63:0]  hash_reg [8];
    logic [63:0]  work_reg [8];          // a..h
    logic [63:0]  sched_reg [16];        // block store, then schedule window
    logic [127:0] count_reg, count_next;
    logic [3:0]   slot_reg, slot_next;
    logic [6:0]   round_reg, round_next;
    logic [2:0]   emit_reg, emit_next;
    logic         last_reg, last_next;     // padding of a message under way
    logic         marker_reg, marker_next; // 0x80 word still owed (full last word)
    logic         len_ok_reg, len_ok_next; // this block takes the length at 14/15
    logic         len_done_reg, len_done_next; // length written, next fold is final

    // word entering the block this cycle
    logic         push;
    logic [63:0]  push_word;
    logic         start_comp;

    // round unit
    logic [63:0] t1, t2, s0, s1, w_new;
    logic [63:0] a, b, c, e, f, g;

    // last-word shaping
    logic [3:0]  nb;
    logic [63:0] keep, marked;

    always_comb begin
        nb = (s_data.valid_bytes > 4'd8) ? 4'd8 : s_data.valid_bytes;
        // eight valid bytes shift the mask fully out, so keep is all ones
        keep = ~(64'hffffffffffffffff >> {nb, 3'b000});
        marked = (s_data.message_word & keep) | (sha512_pkg::PAD_WORD >> {nb, 3'b000});
    end

    always_comb begin
        a = work_reg[0]; b = work_reg[1]; c = work_reg[2];
        e = work_reg[4]; f = work_reg[5]; g = work_reg[6];
        t1 = work_reg[7]
           + (sha512_pkg::ror(e, 14) ^ sha512_pkg::ror(e, 18) ^ sha512_pkg::ror(e, 41))
           + ((e & f) ^ (~e & g)) + sha512_pkg::round_k(round_reg) + sched_reg[0];
        t2 = (sha512_pkg::ror(a, 28) ^ sha512_pkg::ror(a, 34) ^ sha512_pkg::ror(a, 39))
           + ((a & b) ^ (a & c) ^ (b & c));
        s0 = sha512_pkg::ror(sched_reg[1], 1) ^ sha512_pkg::ror(sched_reg[1], 8)
           ^ (sched_reg[1] >> 7);
        s1 = sha512_pkg::ror(sched_reg[14], 19) ^ sha512_pkg::ror(sched_reg[14], 61)
           ^ (sched_reg[14] >> 6);
        w_new = s1 + sched_reg[9] + s0 + sched_reg[0];
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        round_next    = round_reg;
        emit_next     = emit_reg;
        last_next     = last_reg;
        marker_next   = marker_reg;
        len_ok_next   = len_ok_reg;
        len_done_next = len_done_reg;
        push          = 1'b0;
        push_word     = 64'd0;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        start_comp    = 1'b0;
        case (state_reg)
            sha512_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    push      = 1'b1;
                    slot_next = slot_reg + 4'd1;
                    if (!s_data.end_of_message) begin
                        push_word  = s_data.message_word;
                        count_next = count_reg + 128'd64;
                    end else begin
                        count_next = count_reg + {121'd0, nb, 3'b000};
                        last_next  = 1'b1;
                        state_next = sha512_pkg::ST_PAD;
                        if (nb == 4'd8) begin
                            // full word: marker opens the next word
                            push_word   = s_data.message_word;
                            marker_next = 1'b1;
                        end else begin
                            push_word   = marked;
                            // marker at 14 leaves no room for the length here
                            len_ok_next = (slot_reg != sha512_pkg::LEN_SLOT);
                        end
                    end
                    if (slot_reg == 4'd15) begin
                        start_comp = 1'b1;
                        state_next = sha512_pkg::ST_ROUND;
                    end
                end
            end
            sha512_pkg::ST_PAD: begin
                push      = 1'b1;
                slot_next = slot_reg + 4'd1;
                if (marker_reg) begin
                    push_word   = sha512_pkg::PAD_WORD;
                    marker_next = 1'b0;
                    len_ok_next = (slot_reg != sha512_pkg::LEN_SLOT);
                end else if (len_ok_reg && slot_reg == sha512_pkg::LEN_SLOT) begin
                    push_word = count_reg[127:64];
                end else if (len_ok_reg && slot_reg == 4'd15) begin
                    push_word     = count_reg[63:0];
                    len_done_next = 1'b1;
                end else begin
                    push_word = 64'd0;
                end
                if (slot_reg == 4'd15) begin
                    start_comp = 1'b1;
                    state_next = sha512_pkg::ST_ROUND;
                end
            end
            sha512_pkg::ST_ROUND: begin
                round_next = round_reg + 7'd1;
                if (round_reg == 7'd79) begin
                    round_next = 7'd0;
                    state_next = sha512_pkg::ST_FOLD;
                end
            end
            sha512_pkg::ST_FOLD: begin
                if (!last_reg) begin
                    state_next = sha512_pkg::ST_IDLE;
                end else if (len_done_reg) begin
                    state_next = sha512_pkg::ST_EMIT;
                end else begin
                    // fresh block after a full one: length fits at 14/15
                    state_next  = sha512_pkg::ST_PAD;
                    len_ok_next = 1'b1;
                end
            end
            sha512_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == 3'd7) begin
                        state_next    = sha512_pkg::ST_IDLE;
                        count_next    = 128'd0;
                        last_next     = 1'b0;
                        len_ok_next   = 1'b0;
                        len_done_next = 1'b0;
                    end
                end
            end
            default: state_next = sha512_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha512_pkg::ST_IDLE;
            count_reg    <= 128'd0;
            slot_reg     <= 4'd0;
            round_reg    <= 7'd0;
            emit_reg     <= 3'd0;
            last_reg     <= 1'b0;
            marker_reg   <= 1'b0;
            len_ok_reg   <= 1'b0;
            len_done_reg <= 1'b0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= sha512_pkg::init_hash(3'(i));
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            slot_reg     <= slot_next;
            round_reg    <= round_next;
            emit_reg     <= emit_next;
            last_reg     <= last_next;
            marker_reg   <= marker_next;
            len_ok_reg   <= len_ok_next;
            len_done_reg <= len_done_next;
            if (state_reg == sha512_pkg::ST_FOLD) begin
                for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + work_reg[i];
            end else if (state_reg == sha512_pkg::ST_EMIT && m_ready && emit_reg == 3'd7) begin
                for (int i = 0; i < 8; i++) hash_reg[i] <= sha512_pkg::init_hash(3'(i));
            end
        end
    end

    // block store and schedule window share one shift register
    always_ff @(posedge aclk) begin
        if (push) begin
            sched_reg[slot_reg] <= push_word;
        end else if (state_reg == sha512_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) sched_reg[i] <= sched_reg[i + 1];
            sched_reg[15] <= w_new;
        end
        if (start_comp) begin
            for (int i = 0; i < 8; i++) work_reg[i] <= hash_reg[i];
        end else if (state_reg == sha512_pkg::ST_ROUND) begin
            work_reg[7] <= g;
            work_reg[6] <= f;
            work_reg[5] <= e;
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= c;
            work_reg[2] <= b;
            work_reg[1] <= a;
            work_reg[0] <= t1 + t2;
        end
    end

    assign m_data.digest_word = hash_reg[emit_reg];
    assign m_data.digest_done = (emit_reg == 3'd7);

endmodule

/* sim/sha512_hash_engine_test.sv */
// Testbench for the SHA-512 hash engine: directed and random messages checked against a predictor.
`timescale 1ns / 1ps
module sha512_hash_engine_test;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sha512_pkg::in_item_t  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sha512_pkg::out_item_t m_data;

    sha512_hash_engine u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Predictor state: running hash, 128-bit bit count, block being gathered.
    logic [63:0]  hash_h [8];
    logic [127:0] msg_bits;
    logic [63:0]  blk_words [16];
    int unsigned  blk_fill;

    sha512_pkg::out_item_t expected_digests[$];
    int        error_count = 0;
    bit        quiet_mode = 1'b0;   // no idling on either side when set

    localparam logic [63:0] H0 [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam logic [63:0] RK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    function automatic logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic hash_clear();
        for (int i = 0; i < 8; i++) hash_h[i] = H0[i];
        for (int i = 0; i < 16; i++) blk_words[i] = '0;
        msg_bits = '0;
        blk_fill = 0;
    endtask

    // One 80-round compression of the gathered block into the running hash.
    task automatic fold_block();
        logic [63:0] w [80];
        logic [63:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 16; r++) w[r] = blk_words[r];
        for (int r = 16; r < 80; r++)
            w[r] = (rotr(w[r-2], 19) ^ rotr(w[r-2], 61) ^ (w[r-2] >> 6)) + w[r-7]
                 + (rotr(w[r-15], 1) ^ rotr(w[r-15], 8) ^ (w[r-15] >> 7)) + w[r-16];
        {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                    hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
        for (int r = 0; r < 80; r++) begin
            t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
               + RK[r] + w[r];
            t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    task automatic gather_word(logic [63:0] wd);
        blk_words[blk_fill] = wd;
        blk_fill++;
        if (blk_fill == 16) begin
            fold_block();
            blk_fill = 0;
        end
    endtask

    // Advance the predictor by one accepted transaction; queue the digest on the last word.
    task automatic predict_digest(sha512_pkg::in_item_t it);
        int unsigned nb;
        logic [63:0] keep;
        sha512_pkg::out_item_t o;
        if (!it.end_of_message) begin
            msg_bits += 128'd64;
            gather_word(it.message_word);
            return;
        end
        nb = (it.valid_bytes > 4'd8) ? 8 : it.valid_bytes;
        msg_bits += 128'(nb * 8);
        if (nb == 8) begin
            gather_word(it.message_word);
            gather_word(sha512_pkg::PAD_WORD);
        end else begin
            keep = (nb == 0) ? 64'd0 : ~64'd0 << (64 - 8 * nb);
            gather_word((it.message_word & keep) | (64'h80 << (56 - 8 * nb)));
        end
        // no room for the length: close this block with zeros first
        if (blk_fill > 14)
            while (blk_fill != 0) gather_word('0);
        while (blk_fill < 14) gather_word('0);
        gather_word(msg_bits[127:64]);
        gather_word(msg_bits[63:0]);
        for (int k = 0; k < 8; k++) begin
            o.digest_word = hash_h[k];
            o.digest_done = (k == 7);
            expected_digests.push_back(o);
        end
        hash_clear();
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Send one transaction at the falling edge and hold it until accepted.
    // Valid stays high on return; the next send or wait_digests settles it.
    task automatic send_word(logic [63:0] wd, logic [3:0] nb, logic eom);
        sha512_pkg::in_item_t it;
        it.message_word = wd;
        it.valid_bytes = nb;
        it.end_of_message = eom;
        while (!quiet_mode && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predict_digest(it);
        @(negedge aclk);
    endtask

    // Message of nwords random words, then a random last word with last_bytes valid bytes.
    task automatic send_message(int unsigned nwords, int unsigned last_bytes);
        for (int i = 0; i < nwords; i++)
            send_word({$urandom, $urandom}, 4'($urandom), 1'b0);
        send_word({$urandom, $urandom}, 4'(last_bytes), 1'b1);
    endtask

    task automatic wait_digests();
        s_valid <= 1'b0;
        while (expected_digests.size() != 0) @(negedge aclk);
    endtask

    // Receiver: random stalls, compares each digest transaction with the oldest expectation.
    always @(negedge aclk)
        m_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 7);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_digests.size() == 0) begin
                report_mismatch("unexpected digest", m_data.digest_word, '0);
            end else begin
                sha512_pkg::out_item_t exp_o;
                exp_o = expected_digests.pop_front();
                if (m_data.digest_word !== exp_o.digest_word)
                    report_mismatch("digest_word", m_data.digest_word, exp_o.digest_word);
                if (m_data.digest_done !== exp_o.digest_done)
                    report_mismatch("digest_done", 64'(m_data.digest_done),
                                    64'(exp_o.digest_done));
            end
        end
    end

    task automatic test_empty_and_short();
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);   // empty message
        send_word(64'h6162_6300_0000_0000, 4'd3, 1'b1);   // "abc"
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1);   // junk in the invalid low byte
        send_word(64'h0000_0000_0000_0000, 4'd1, 1'b1);
    endtask

    task automatic test_byte_counts();
        // every count, including those above eight which clamp to eight
        for (int nb = 0; nb < 16; nb++)
            send_message(1, nb);
    endtask

    task automatic test_block_edges();
        send_message(13, 8);   // full last word pushes the length into a second block
        send_message(14, 3);   // pad lands in slot 14
        send_message(15, 0);   // pad in the last slot
        send_message(15, 8);   // exactly one block of data, then pad block
        wait_digests();        // sender holds off until all digests are back
        send_message(16, 5);
        send_message(31, 15);
    endtask

    task automatic test_random();
        int unsigned sent = 0;
        int unsigned n;
        // first stretch with no idling at all
        quiet_mode = 1'b1;
        for (int i = 0; i < 4; i++) begin
            n = $urandom_range(5);
            send_message(n, $urandom_range(15));
            sent += n + 1;
        end
        wait_digests();
        quiet_mode = 1'b0;
        while (sent < 125) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(15);
            send_message(n, $urandom_range(15));
            sent += n + 1;
        end
    endtask

    initial begin
        hash_clear();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_and_short();
        test_byte_counts();
        test_block_edges();
        test_random();
        wait_digests();
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_digests.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* files.f */
sv/sha512_pkg.sv
sv/sha512_hash_engine.sv
sim/sha512_hash_engine_test.sv
